>>> rtl/tcau_pkg.sv
// package for the traffic cell automaton update block
// opcodes, register indexes, field widths and shared structs; no dependencies
package tcau_pkg;

  localparam int unsigned CellsDefault = 1024;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned SpdW   = 5;
  localparam int unsigned VelW   = 4;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  localparam logic [SpdW-1:0] SpeedEmpty = 5'h1F;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_SWAP   = 2'd2,
    OP_READ   = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_VEL   = 3'd0,
    CFG_SAFETY    = 3'd1,
    CFG_DAWDLE    = 3'd2,
    CFG_SS_PROB   = 3'd3,
    CFG_SS_ENABLE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [VelW-1:0]  max_vel;
    logic [VelW-1:0]  safety;
    logic [ProbW-1:0] dawdle;
    logic [ProbW-1:0] ss_prob;
    logic             ss_en;
  } cfg_t;

  typedef struct packed {
    logic            status;
    logic [SpdW-1:0] speed;
    logic [IdxW-1:0] dest;
    logic [VelW-1:0] gap;
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

>>> rtl/tcau_speed_mem.sv
// speed bank memory: both banks, one entry per cell, {occupied, speed}
// one write and one registered read per cycle; uses tcau_pkg
module tcau_speed_mem #(
  parameter int unsigned AW = 10
) (
  input  logic                 clk_i,
  input  tcau_pkg::mem_ctl_t   ctl_i,
  input  logic [AW:0]          rd_addr_i,
  input  logic [AW:0]          wr_addr_i,
  input  logic [tcau_pkg::SpdW-1:0] wr_data_i,
  output logic [tcau_pkg::SpdW-1:0] rd_data_o
);
  import tcau_pkg::*;

  logic [SpdW-1:0] mem [2**(AW+1)];
  logic [SpdW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/tcau_succ_mem.sv
// successor table memory, one downstream cell per cell
// one write and one registered read per cycle; uses tcau_pkg
module tcau_succ_mem #(
  parameter int unsigned AW = 10
) (
  input  logic               clk_i,
  input  tcau_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]      rd_addr_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [AW-1:0]      wr_data_i,
  output logic [AW-1:0]      rd_data_o
);
  import tcau_pkg::*;

  logic [AW-1:0] mem [2**AW];
  logic [AW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/tcau_seq.sv
// sequencer: index wrap, opcode execution, successor walk and hop, bank clearing
// drives tcau_speed_mem and tcau_succ_mem; uses tcau_pkg
module tcau_seq #(
  parameter int unsigned CELLS = tcau_pkg::CellsDefault,
  parameter int unsigned AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic [tcau_pkg::IdxW-1:0]   cell_i,
  input  logic [tcau_pkg::SpdW-1:0]   speed_i,
  input  logic [tcau_pkg::IdxW-1:0]   succ_i,
  input  logic [tcau_pkg::ProbW-1:0]  rnd_i,
  input  tcau_pkg::cfg_t              cfg_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output tcau_pkg::res_t              res_o,
  output tcau_pkg::mem_ctl_t          spd_ctl_o,
  output logic [AW:0]                 spd_rd_addr_o,
  output logic [AW:0]                 spd_wr_addr_o,
  output logic [tcau_pkg::SpdW-1:0]   spd_wr_data_o,
  input  logic [tcau_pkg::SpdW-1:0]   spd_rd_data_i,
  output tcau_pkg::mem_ctl_t          suc_ctl_o,
  output logic [AW-1:0]               suc_rd_addr_o,
  output logic [AW-1:0]               suc_wr_addr_o,
  output logic [AW-1:0]               suc_wr_data_o,
  input  logic [AW-1:0]               suc_rd_data_i
);
  import tcau_pkg::*;

  localparam logic [19:0] Recip   = 20'((1 << 20) / CELLS);
  localparam logic [26:0] CellsW  = 27'(CELLS);
  localparam logic [AW-1:0] LastCell = AW'(CELLS - 1);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_QUO   = 12'b000000000100,
    S_REM   = 12'b000000001000,
    S_EXEC  = 12'b000000010000,
    S_RDW   = 12'b000000100000,
    S_UCUR  = 12'b000001000000,
    S_WCHK  = 12'b000010000000,
    S_RAND  = 12'b000100000000,
    S_HOP   = 12'b001000000000,
    S_UWR   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic cur_bank_q, cur_bank_d;
  logic swap_q, swap_d;
  logic [AW:0] clr_q, clr_d, clr_end_q, clr_end_d;

  logic [1:0]       op_q;
  logic [IdxW-1:0]  cell_raw_q, succ_raw_q;
  logic [SpdW-1:0]  spd_in_q;
  logic [ProbW-1:0] rnd_q;
  logic [IdxW-1:0]  qc_q, qc_d, qs_q, qs_d;
  logic [AW-1:0]    cell_q, cell_d, succ_q, succ_d;
  logic [VelW-1:0]  cur_spd_q, cur_spd_d, v_q, v_d, gap_q, gap_d, h_q, h_d;
  logic [4:0]       lim_q, lim_d, i_q, i_d;
  logic [AW-1:0]    s0_q, s0_d, dest_q, dest_d;
  res_t             res_q, res_d;

  logic             accept;
  logic [29:0]      prod_c, prod_s;
  logic [26:0]      rem_c, rem_s;
  logic [VelW-1:0]  vn, vm;
  logic [4:0]       lim_n;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  // index wrap by reciprocal, quotient first, then remainder with one correction
  assign prod_c = 30'(cell_raw_q) * 30'(Recip);
  assign prod_s = 30'(succ_raw_q) * 30'(Recip);

  always_comb begin
    rem_c = 27'(cell_raw_q) - 27'(qc_q) * CellsW;
    rem_s = 27'(succ_raw_q) - 27'(qs_q) * CellsW;
    if (rem_c >= CellsW) begin
      rem_c = rem_c - CellsW;
    end
    if (rem_s >= CellsW) begin
      rem_s = rem_s - CellsW;
    end
  end

  assign vn    = (spd_rd_data_i[3:0] < cfg_i.max_vel) ? spd_rd_data_i[3:0] + 4'd1
                                                      : spd_rd_data_i[3:0];
  assign lim_n = 5'(vn) + 5'(cfg_i.safety);

  always_comb begin
    vm = (v_q > gap_q) ? gap_q : v_q;
    if (cur_spd_q == '0 && cfg_i.ss_en) begin
      if (rnd_q < cfg_i.ss_prob) begin
        vm = '0;
      end
    end else if (rnd_q < cfg_i.dawdle && vm != '0) begin
      vm = vm - 4'd1;
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_bank_d = cur_bank_q;
    swap_d     = swap_q;
    clr_d      = clr_q;
    clr_end_d  = clr_end_q;
    qc_d       = qc_q;
    qs_d       = qs_q;
    cell_d     = cell_q;
    succ_d     = succ_q;
    cur_spd_d  = cur_spd_q;
    v_d        = v_q;
    gap_d      = gap_q;
    h_d        = h_q;
    lim_d      = lim_q;
    i_d        = i_q;
    s0_d       = s0_q;
    dest_d     = dest_q;
    res_d      = res_q;

    spd_ctl_o     = '0;
    spd_rd_addr_o = {cur_bank_q, cell_q};
    spd_wr_addr_o = {cur_bank_q, cell_q};
    spd_wr_data_o = '0;
    suc_ctl_o     = '0;
    suc_rd_addr_o = cell_q;
    suc_wr_addr_o = cell_q;
    suc_wr_data_o = succ_q;

    unique case (state_q)
      S_CLEAR: begin
        spd_ctl_o.wr_en = 1'b1;
        spd_wr_addr_o   = clr_q;
        if (clr_q == clr_end_q) begin
          state_d = swap_q ? S_OUT : S_IDLE;
          swap_d  = 1'b0;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_QUO;
        end
      end
      S_QUO: begin
        qc_d    = prod_c[29:20];
        qs_d    = prod_s[29:20];
        state_d = S_REM;
      end
      S_REM: begin
        cell_d  = rem_c[AW-1:0];
        succ_d  = rem_s[AW-1:0];
        state_d = S_EXEC;
      end
      S_EXEC: begin
        res_d = '0;
        unique case (opcode_e'(op_q))
          OP_WRITE: begin
            spd_ctl_o.wr_en = 1'b1;
            spd_wr_data_o   = spd_in_q[4] ? '0 : {1'b1, spd_in_q[3:0]};
            suc_ctl_o.wr_en = 1'b1;
            res_d.speed     = spd_in_q[4] ? SpeedEmpty : spd_in_q;
            state_d         = S_OUT;
          end
          OP_READ: begin
            spd_ctl_o.rd_en = 1'b1;
            state_d         = S_RDW;
          end
          OP_SWAP: begin
            // old current bank becomes the next bank and is emptied
            cur_bank_d = ~cur_bank_q;
            clr_d      = {cur_bank_q, {AW{1'b0}}};
            clr_end_d  = {cur_bank_q, LastCell};
            swap_d     = 1'b1;
            state_d    = S_CLEAR;
          end
          OP_UPDATE: begin
            spd_ctl_o.rd_en = 1'b1;
            suc_ctl_o.rd_en = 1'b1;
            state_d         = S_UCUR;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_RDW: begin
        res_d.speed = spd_rd_data_i[4] ? {1'b0, spd_rd_data_i[3:0]} : SpeedEmpty;
        state_d     = S_OUT;
      end
      S_UCUR: begin
        if (!spd_rd_data_i[4]) begin
          res_d.status = 1'b1;
          res_d.speed  = SpeedEmpty;
          state_d      = S_OUT;
        end else begin
          cur_spd_d = spd_rd_data_i[3:0];
          v_d       = vn;
          gap_d     = vn;
          s0_d      = suc_rd_data_i;
          lim_d     = lim_n;
          i_d       = '0;
          if (lim_n == '0) begin
            state_d = S_RAND;
          end else begin
            spd_ctl_o.rd_en = 1'b1;
            spd_rd_addr_o   = {cur_bank_q, suc_rd_data_i};
            suc_ctl_o.rd_en = 1'b1;
            suc_rd_addr_o   = suc_rd_data_i;
            state_d         = S_WCHK;
          end
        end
      end
      S_WCHK: begin
        if (spd_rd_data_i[4]) begin
          gap_d   = (i_q <= 5'(cfg_i.safety)) ? '0 : 4'(i_q - 5'(cfg_i.safety));
          state_d = S_RAND;
        end else if (i_q + 5'd1 == lim_q) begin
          state_d = S_RAND;
        end else begin
          i_d             = i_q + 5'd1;
          spd_ctl_o.rd_en = 1'b1;
          spd_rd_addr_o   = {cur_bank_q, suc_rd_data_i};
          suc_ctl_o.rd_en = 1'b1;
          suc_rd_addr_o   = suc_rd_data_i;
        end
      end
      S_RAND: begin
        v_d = vm;
        if (vm == '0) begin
          dest_d  = cell_q;
          state_d = S_UWR;
        end else begin
          dest_d = s0_q;
          h_d    = vm - 4'd1;
          if (vm == 4'd1) begin
            state_d = S_UWR;
          end else begin
            suc_ctl_o.rd_en = 1'b1;
            suc_rd_addr_o   = s0_q;
            state_d         = S_HOP;
          end
        end
      end
      S_HOP: begin
        dest_d = suc_rd_data_i;
        if (h_q == 4'd1) begin
          state_d = S_UWR;
        end else begin
          h_d             = h_q - 4'd1;
          suc_ctl_o.rd_en = 1'b1;
          suc_rd_addr_o   = suc_rd_data_i;
        end
      end
      S_UWR: begin
        spd_ctl_o.wr_en = 1'b1;
        spd_wr_addr_o   = {~cur_bank_q, dest_q};
        spd_wr_data_o   = {1'b1, v_q};
        res_d.status    = 1'b0;
        res_d.speed     = {1'b0, v_q};
        res_d.dest      = IdxW'(dest_q);
        res_d.gap       = gap_q;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cur_bank_q <= 1'b0;
      swap_q     <= 1'b0;
      clr_q      <= '0;
      clr_end_q  <= '1;
    end else begin
      state_q    <= state_d;
      cur_bank_q <= cur_bank_d;
      swap_q     <= swap_d;
      clr_q      <= clr_d;
      clr_end_q  <= clr_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_i;
      cell_raw_q <= cell_i;
      spd_in_q   <= speed_i;
      succ_raw_q <= succ_i;
      rnd_q      <= rnd_i;
    end
    qc_q      <= qc_d;
    qs_q      <= qs_d;
    cell_q    <= cell_d;
    succ_q    <= succ_d;
    cur_spd_q <= cur_spd_d;
    v_q       <= v_d;
    gap_q     <= gap_d;
    h_q       <= h_d;
    lim_q     <= lim_d;
    i_q       <= i_d;
    s0_q      <= s0_d;
    dest_q    <= dest_d;
    res_q     <= res_d;
  end

endmodule

>>> rtl/traffic_cell_automaton_update.sv
// traffic cell automaton update: write, read, swap and update; update on an empty cell
// reads only that cell, else it makes one memory read per successor hop: up to speed plus safety walk
// steps, then up to speed minus one hops; swap empties the old current bank; one item in flight at a time
// reset: async low; afterwards both banks are swept empty with the input stalled;
// config is taken at any time, one write a cycle
module traffic_cell_automaton_update #(
  parameter int unsigned CELLS = tcau_pkg::CellsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // cell_index[9:0], cell_speed[14:10], successor_index[24:15],
  // random_fraction[40:25], zero fill above
  input  logic [tcau_pkg::InDataW-1:0]    s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // speed_out[4:0], destination[14:5], free_gap[18:15], zero fill above
  output logic [tcau_pkg::OutDataW-1:0]   m_axis_tdata,
  // status[0]
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcau_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tcau_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tcau_pkg::*;

  localparam int unsigned AW = $clog2(CELLS);

  cfg_t     cfg_q;
  res_t     res, out_q;
  logic     res_valid, res_ready;
  logic     out_valid_q;

  mem_ctl_t        spd_ctl, suc_ctl;
  logic [AW:0]     spd_rd_addr, spd_wr_addr;
  logic [SpdW-1:0] spd_wr_data, spd_rd_data;
  logic [AW-1:0]   suc_rd_addr, suc_wr_addr, suc_wr_data, suc_rd_data;

  // registers are written whenever offered
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_vel <= 4'd5;
      cfg_q.safety  <= '0;
      cfg_q.dawdle  <= '0;
      cfg_q.ss_prob <= '0;
      cfg_q.ss_en   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_VEL:   cfg_q.max_vel <= cfg_data_i[VelW-1:0];
        CFG_SAFETY:    cfg_q.safety  <= cfg_data_i[VelW-1:0];
        CFG_DAWDLE:    cfg_q.dawdle  <= cfg_data_i;
        CFG_SS_PROB:   cfg_q.ss_prob <= cfg_data_i;
        CFG_SS_ENABLE: cfg_q.ss_en   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // output register parts the sequencer from the master side
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {5'b0, out_q.gap, out_q.dest, out_q.speed};

  tcau_seq #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tuser),
    .cell_i        (s_axis_tdata[9:0]),
    .speed_i       (s_axis_tdata[14:10]),
    .succ_i        (s_axis_tdata[24:15]),
    .rnd_i         (s_axis_tdata[40:25]),
    .cfg_i         (cfg_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .spd_ctl_o     (spd_ctl),
    .spd_rd_addr_o (spd_rd_addr),
    .spd_wr_addr_o (spd_wr_addr),
    .spd_wr_data_o (spd_wr_data),
    .spd_rd_data_i (spd_rd_data),
    .suc_ctl_o     (suc_ctl),
    .suc_rd_addr_o (suc_rd_addr),
    .suc_wr_addr_o (suc_wr_addr),
    .suc_wr_data_o (suc_wr_data),
    .suc_rd_data_i (suc_rd_data)
  );

  tcau_speed_mem #(
    .AW (AW)
  ) u_speed_mem (
    .clk_i     (clk_i),
    .ctl_i     (spd_ctl),
    .rd_addr_i (spd_rd_addr),
    .wr_addr_i (spd_wr_addr),
    .wr_data_i (spd_wr_data),
    .rd_data_o (spd_rd_data)
  );

  tcau_succ_mem #(
    .AW (AW)
  ) u_succ_mem (
    .clk_i     (clk_i),
    .ctl_i     (suc_ctl),
    .rd_addr_i (suc_rd_addr),
    .wr_addr_i (suc_wr_addr),
    .wr_data_i (suc_wr_data),
    .rd_data_o (suc_rd_data)
  );

endmodule

>>> rtl/tcau_checker.sv
// port-level checks for traffic_cell_automaton_update, with its bind
// sees only the top-level ports; uses tcau_pkg
module tcau_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [tcau_pkg::InDataW-1:0]   s_axis_tdata,
  input logic [1:0]                     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tcau_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [tcau_pkg::CfgIdxW-1:0]   cfg_index_i,
  input logic [tcau_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tcau_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // update on an empty cell reports an empty speed and no move
  a_empty_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[4:0] == SpeedEmpty && m_axis_tdata[18:5] == '0)
    else $error("bad empty-cell result");

  // an empty speed never comes with a destination or gap
  a_empty_spd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[18:5] == '0)
    else $error("empty speed with move fields");

endmodule

bind traffic_cell_automaton_update tcau_checker u_tcau_checker (.*);
